// ----- hdl/mtxmul_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtxmul_pkg: shared types and constants for the matrix multiply core
// Command codes, queue word layout, back-end states and parameter defaults.
// ----------------------------------------------------------------------------
package mtxmul_pkg;

  // Fixed port widths
  localparam int ELEM_PORT_W = 32;
  localparam int IDX_PORT_W  = 2;
  localparam int MODE_W      = 2;

  // Parameter defaults
  localparam int DIM_DEF        = 4;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Command queue depth; a power of two so the pointers wrap on their own
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Command word mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD_L  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_R  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_L,
    OP_LOAD_R,
    OP_COMPUTE
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [IDX_PORT_W-1:0]  row;
    logic [IDX_PORT_W-1:0]  col;
    logic [ELEM_PORT_W-1:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t ent;
  } q_push_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage

// ----- hdl/mtxmul_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtxmul_front: command intake
// Registers each accepted word, decodes it, drops unused modes and
// out-of-range loads, and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module mtxmul_front #(
  parameter int DIM = mtxmul_pkg::DIM_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  output logic                                  cmd_stall,
  input  logic [mtxmul_pkg::MODE_W-1:0]         mode,
  input  logic [mtxmul_pkg::IDX_PORT_W-1:0]     row,
  input  logic [mtxmul_pkg::IDX_PORT_W-1:0]     col,
  input  logic signed [mtxmul_pkg::ELEM_PORT_W-1:0] element,
  input  logic                                  q_full,
  output mtxmul_pkg::q_push_t                   q_push
);
  import mtxmul_pkg::*;

  logic     f_valid;
  q_entry_t f_ent;
  logic     take;
  logic     keep;
  logic     in_range;
  q_entry_t dec;

  assign cmd_stall = f_valid && q_full;
  assign take      = !f_valid || !q_full;

  always_comb begin
    in_range = (int'(row) < DIM) && (int'(col) < DIM);
    dec.row  = row;
    dec.col  = col;
    dec.data = element;
    dec.op   = OP_COMPUTE;
    keep     = 1'b0;
    case (mode)
      MODE_LOAD_L: begin
        dec.op = OP_LOAD_L;
        keep   = in_range;
      end
      MODE_LOAD_R: begin
        dec.op = OP_LOAD_R;
        keep   = in_range;
      end
      MODE_COMPUTE: begin
        dec.op = OP_COMPUTE;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= cmd_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_ent <= dec;
    end
  end

  assign q_push.valid = f_valid && !q_full;
  assign q_push.ent   = f_ent;

endmodule

// ----- hdl/mtxmul_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtxmul_queue: command queue
// Small FIFO between intake and execution; head word is read in place.
// ----------------------------------------------------------------------------
module mtxmul_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  mtxmul_pkg::q_push_t  q_push,
  input  logic                 pop,
  output logic                 q_full,
  output logic                 q_empty,
  output mtxmul_pkg::q_entry_t q_head
);
  import mtxmul_pkg::*;

  q_entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;
  logic                 do_pop;

  assign q_full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_empty = (count == '0);
  assign q_head  = mem[rd_ptr];
  assign do_pop  = pop && !q_empty;

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem[wr_ptr] <= q_push.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({q_push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/mtxmul_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtxmul_back: execution engine
// Banked left/right stores, DIM multiplier lanes and a four-stage pipeline
// that produces one product element per cycle, unless the result is stalled, into the result register.
// ----------------------------------------------------------------------------
module mtxmul_back #(
  parameter int DIM        = mtxmul_pkg::DIM_DEF,
  parameter int ELEM_WIDTH = mtxmul_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mtxmul_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_empty,
  input  mtxmul_pkg::q_entry_t                      q_head,
  output logic                                      pop,
  output logic                                      res_valid,
  input  logic                                      res_stall,
  output logic signed [mtxmul_pkg::ELEM_PORT_W-1:0] product,
  output logic [mtxmul_pkg::IDX_PORT_W-1:0]         out_row,
  output logic [mtxmul_pkg::IDX_PORT_W-1:0]         out_col,
  output logic                                      last
);
  import mtxmul_pkg::*;

  localparam int ID_W   = $clog2(DIM);
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int SUM_A  = SH_W + $clog2(DIM) + 1;
  localparam int SUM_W  = (SUM_A > ELEM_WIDTH + 1) ? SUM_A : ELEM_WIDTH + 1;
  localparam logic [ID_W-1:0] LAST_IDX = ID_W'(DIM - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    SUM_W'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - 1'b1;

  bk_state_t state, state_next;
  logic [ID_W-1:0] i, j;
  logic issue, adv, wr_l, wr_r, at_end;

  // Stores: bank k of the left store holds column k (addressed by row),
  // bank k of the right store holds row k (addressed by column).
  logic signed [ELEM_WIDTH-1:0] lmem [DIM][DIM];
  logic signed [ELEM_WIDTH-1:0] rmem [DIM][DIM];
  logic [DIM-1:0] lval [DIM];
  logic [DIM-1:0] rval [DIM];
  logic [ID_W-1:0] w_row, w_col;
  logic signed [ELEM_WIDTH-1:0] wdata;

  // Pipeline
  logic s1_valid, s2_valid, s3_valid;
  logic s1_last, s2_last, s3_last;
  logic [ID_W-1:0] s1_i, s1_j, s2_i, s2_j, s3_i, s3_j;
  logic signed [ELEM_WIDTH-1:0] l_rd [DIM];
  logic signed [ELEM_WIDTH-1:0] r_rd [DIM];
  logic l_rv [DIM];
  logic r_rv [DIM];
  logic signed [ELEM_WIDTH-1:0] l_op [DIM];
  logic signed [ELEM_WIDTH-1:0] r_op [DIM];
  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [SH_W-1:0] term [DIM];
  logic signed [SUM_W-1:0] acc, s3_sum;
  logic signed [ELEM_WIDTH-1:0] sat;

  assign adv    = !res_valid || !res_stall;
  assign at_end = (i == LAST_IDX) && (j == LAST_IDX);
  assign w_row  = ID_W'(q_head.row);
  assign w_col  = ID_W'(q_head.col);
  assign wdata  = signed'(q_head.data[ELEM_WIDTH-1:0]);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    wr_l       = 1'b0;
    wr_r       = 1'b0;
    issue      = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (q_head.op)
            OP_LOAD_L:  wr_l = 1'b1;
            OP_LOAD_R:  wr_r = 1'b1;
            OP_COMPUTE: state_next = BK_RUN;
            default:    ;
          endcase
        end
      end
      BK_RUN: begin
        issue = adv;
        if (adv && at_end) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else if (state == BK_IDLE) begin
      i <= '0;
      j <= '0;
    end else if (issue) begin
      if (j == LAST_IDX) begin
        j <= '0;
        i <= i + 1'b1;
      end else begin
        j <= j + 1'b1;
      end
    end
  end

  // Store writes
  always_ff @(posedge clk) begin
    if (wr_l) begin
      lmem[w_col][w_row] <= wdata;
    end
    if (wr_r) begin
      rmem[w_row][w_col] <= wdata;
    end
  end

  // Entry valid bits; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIM; k++) begin
        lval[k] <= '0;
        rval[k] <= '0;
      end
    end else begin
      if (wr_l) begin
        lval[w_col][w_row] <= 1'b1;
      end
      if (wr_r) begin
        rval[w_row][w_col] <= 1'b1;
      end
    end
  end

  // Stage 1: registered bank reads, row i of left and column j of right
  for (genvar k = 0; k < DIM; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        l_rd[k] <= lmem[k][i];
        r_rd[k] <= rmem[k][j];
        l_rv[k] <= lval[k][i];
        r_rv[k] <= rval[k][j];
      end
    end

    assign l_op[k] = l_rv[k] ? l_rd[k] : '0;
    assign r_op[k] = r_rv[k] ? r_rd[k] : '0;

    // Stage 2: one signed ELEM_WIDTH x ELEM_WIDTH multiplier per lane;
    // the casts only sign-extend
    always_ff @(posedge clk) begin
      if (adv) begin
        prod[k] <= PROD_W'(l_op[k]) * PROD_W'(r_op[k]);
      end
    end

    // Dropping the fraction bits is an arithmetic shift: floor
    assign term[k] = signed'(prod[k][PROD_W-1:FRAC_BITS]);
  end

  // Stage 3: lane sum
  always_comb begin
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      acc = acc + SUM_W'(term[k]);
    end
  end

  // Stage 4: saturate into the result register
  always_comb begin
    if (s3_sum > SAT_MAX) begin
      sat = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    end else if (s3_sum < SAT_MIN) begin
      sat = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    end else begin
      sat = s3_sum[ELEM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_i    <= i;
      s1_j    <= j;
      s1_last <= at_end;
      s2_i    <= s1_i;
      s2_j    <= s1_j;
      s2_last <= s1_last;
      s3_i    <= s2_i;
      s3_j    <= s2_j;
      s3_last <= s2_last;
      s3_sum  <= acc;
      product <= ELEM_PORT_W'(sat);
      out_row <= IDX_PORT_W'(s3_i);
      out_col <= IDX_PORT_W'(s3_j);
      last    <= s3_last;
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue popped while empty");

  a_run_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (!pop && !wr_l && !wr_r))
    else $error("queue touched during compute");

  a_hold_index: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN && !adv) |=> ($stable(i) && $stable(j)))
    else $error("index moved while stalled");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (issue && at_end) |=> (state == BK_IDLE && i == '0 && j == '0))
    else $error("compute did not finish after last element");
`endif

endmodule

// ----- hdl/matrix4x4_multiply_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_multiply_core: DIM x DIM signed fixed-point matrix multiplier
// Loads left/right elements and streams out the product matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall): one word per element load
//   (mode 0 left, mode 1 right, at row/col) or a compute word (mode 2).
//   Mode 3 and loads with row or col >= DIM are taken and dropped.
//   Result channel (res_valid / res_stall): a compute word yields DIM*DIM
//   words in row-major order, last set on the final one. Each is
//   sum_k (L[i][k]*R[k][j]) >> FRAC_BITS, saturated to ELEM_WIDTH bits.
// Timing:
//   Loads sustain one word per cycle through the intake register and the
//   four-entry command queue while cmd_stall is low. A compute word holds the
//   execution engine until its last product word is issued and emits one word
//   per cycle while res_stall is low, set by the DIM multiplier lanes.
// Reset: both stores read as zero, queue and pipeline empty.
// A stalled result freezes the compute pipeline; intake keeps taking words
// until the command queue fills, then cmd_stall rises.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_core #(
  parameter int DIM        = mtxmul_pkg::DIM_DEF,
  parameter int ELEM_WIDTH = mtxmul_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mtxmul_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // command channel
  input  logic                                      cmd_valid,
  output logic                                      cmd_stall,
  input  logic [mtxmul_pkg::MODE_W-1:0]             mode,
  input  logic [mtxmul_pkg::IDX_PORT_W-1:0]         row,
  input  logic [mtxmul_pkg::IDX_PORT_W-1:0]         col,
  input  logic signed [mtxmul_pkg::ELEM_PORT_W-1:0] element,
  // result channel
  output logic                                      res_valid,
  input  logic                                      res_stall,
  output logic signed [mtxmul_pkg::ELEM_PORT_W-1:0] product,
  output logic [mtxmul_pkg::IDX_PORT_W-1:0]         out_row,
  output logic [mtxmul_pkg::IDX_PORT_W-1:0]         out_col,
  output logic                                      last
);
  import mtxmul_pkg::*;

  q_push_t  q_push;   // intake -> queue
  q_entry_t q_head;   // oldest queued word
  logic     q_full;
  logic     q_empty;
  logic     pop;

  // Intake: decode and filter
  mtxmul_front #(
    .DIM (DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .element   (element),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // Decoupling queue
  mtxmul_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .pop     (pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Stores, multiplier lanes and result register
  mtxmul_back #(
    .DIM        (DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .product   (product),
    .out_row   (out_row),
    .out_col   (out_col),
    .last      (last)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for matrix4x4_multiply_core
// Drives element loads and compute words through the command channel and
// checks every streamed product word against a Q16.16 fixed-point model
// kept in the bench. Both channels idle and stall at random, and there are
// stretches with a long result hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb;
  import mtxmul_pkg::*;

  // Mode 3 has no package name; the core takes it and drops it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [31:0] ELEM_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] ELEM_MIN  = 32'h8000_0000;
  localparam logic [31:0] ELEM_NEG1 = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  // Cycles without any accepted word before the run is declared hung.
  // The longest legal quiet spell is the result hold-off (HOLDOFF_CYCLES).
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int TAIL_CYCLES    = 30;

  // One product word as it should leave the core
  typedef struct {
    logic signed [31:0] product;
    logic [1:0]         r;
    logic [1:0]         c;
    logic               last;
  } product_word_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cmd_valid = 1'b0;
  logic                                cmd_stall;
  logic [MODE_W-1:0]                   mode      = MODE_LOAD_L;
  logic [IDX_PORT_W-1:0]               row       = '0;
  logic [IDX_PORT_W-1:0]               col       = '0;
  logic signed [ELEM_PORT_W-1:0]       element   = '0;

  logic                                res_valid;
  logic                                res_stall = 1'b0;
  logic signed [ELEM_PORT_W-1:0]       product;
  logic [IDX_PORT_W-1:0]               out_row;
  logic [IDX_PORT_W-1:0]               out_col;
  logic                                last;

  always #5 clk = ~clk;

  matrix4x4_multiply_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .element   (element),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .product   (product),
    .out_row   (out_row),
    .out_col   (out_col),
    .last      (last)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  // Mirror of the two element stores; both start at zero, like the stores after reset.
  logic signed [31:0] lhs_mat [DIM_DEF][DIM_DEF];
  logic signed [31:0] rhs_mat [DIM_DEF][DIM_DEF];

  product_word_t pending_products[$];   // oldest first

  int mismatches   = 0;
  bit quiet        = 1'b0;   // no idling on either side while set
  int rx_hold_left = 0;      // result hold-off, counted down by the receiver
  int idle_cycles  = 0;

  initial begin
    for (int i = 0; i < DIM_DEF; i++)
      for (int j = 0; j < DIM_DEF; j++) begin
        lhs_mat[i][j] = '0;
        rhs_mat[i][j] = '0;
      end
  end

  // ---------------------------------------------------------------------------
  // Model: apply one accepted command word. Loads update a store, a compute
  // queues all sixteen product words in row-major order. Each term is the
  // full 64-bit product shifted right arithmetically (floor), the four terms
  // are summed in 64 bits and the sum clamps to the signed 32-bit range.
  // Mode 3 does nothing. Row and col are 2 bits, so every load is in range.
  // ---------------------------------------------------------------------------
  task automatic apply_command(input logic [1:0] m, input logic [1:0] r,
                               input logic [1:0] c, input logic [31:0] e);
    longint        acc;
    product_word_t want;
    case (m)
      MODE_LOAD_L: lhs_mat[r][c] = e;
      MODE_LOAD_R: rhs_mat[r][c] = e;
      MODE_COMPUTE: begin
        for (int i = 0; i < DIM_DEF; i++) begin
          for (int j = 0; j < DIM_DEF; j++) begin
            acc = 0;
            for (int k = 0; k < DIM_DEF; k++)
              acc += (longint'(lhs_mat[i][k]) * longint'(rhs_mat[k][j])) >>> FRAC_BITS_DEF;
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            want.product = acc[31:0];
            want.r       = 2'(i);
            want.c       = 2'(j);
            want.last    = (i == DIM_DEF - 1) && (j == DIM_DEF - 1);
            pending_products.push_back(want);
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: optional idle gap, then offer the word and hold it until taken.
  // Valid stays high after acceptance; the next word or an idle cycle
  // replaces it at the same edge, so valid sees only one update per edge.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] m, input logic [1:0] r,
                           input logic [1:0] c, input logic [31:0] e);
    if (!quiet) begin
      while ($urandom_range(99) < 24) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_valid <= 1'b1;
    mode      <= m;
    row       <= r;
    col       <= c;
    element   <= e;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    apply_command(m, r, c, e);
  endtask

  // Drop valid and wait for every queued product word to come back.
  // The wait runs before the first check, so the next valid update is a new step.
  task automatic wait_for_products();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
  endtask

  // Element values: half are moderate Q16.16 numbers (within +/-16.0) so sums
  // stay in range; the rest are full-width random words, 0, -1 and the two bounds.
  function automatic logic [31:0] rand_element();
    case ($urandom_range(9))
      0:       return ELEM_MAX;
      1:       return ELEM_MIN;
      2, 3:    return $urandom();
      4:       return $urandom_range(1) ? 32'h0 : ELEM_NEG1;
      default: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  // Random matrix sets: a burst of loads into either store, then a compute.
  // A few mode 3 words are mixed in as noise and not counted.
  task automatic run_matrix_sets(input int words);
    int sent;
    int loads;
    sent = 0;
    while (sent < words) begin
      loads = $urandom_range(2, 20);
      repeat (loads) begin
        if ($urandom_range(19) == 0)
          send_word(MODE_UNUSED, 2'($urandom), 2'($urandom), $urandom());
        send_word($urandom_range(1) ? MODE_LOAD_R : MODE_LOAD_L,
                  2'($urandom_range(3)), 2'($urandom_range(3)), rand_element());
        sent++;
      end
      // row/col/element are don't-care on a compute; randomize them anyway
      send_word(MODE_COMPUTE, 2'($urandom), 2'($urandom), $urandom());
      sent++;
      if ($urandom_range(9) == 0) begin
        send_word(MODE_COMPUTE, 2'($urandom), 2'($urandom), $urandom());
        sent++;
      end
      if ($urandom_range(7) == 0) wait_for_products();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Cleared stores, dropped mode 3 words, both saturation bounds, and the
  // floor rounding of a small negative term.
  task automatic test_directed();
    send_word(MODE_COMPUTE, 2'd0, 2'd0, 32'h0);          // all zeros after reset
    send_word(MODE_UNUSED, 2'd3, 2'd3, ELEM_MAX);        // taken and dropped
    for (int k = 0; k < DIM_DEF; k++)
      send_word(MODE_LOAD_L, 2'd0, 2'(k), ELEM_MAX);
    for (int k = 0; k < DIM_DEF; k++)
      send_word(MODE_LOAD_R, 2'(k), 2'd0, ELEM_MAX);     // C[0][0] clamps high
    send_word(MODE_LOAD_L, 2'd1, 2'd0, ELEM_MIN);        // C[1][0] clamps low
    send_word(MODE_LOAD_R, 2'd0, 2'd1, ELEM_NEG1);       // MIN * -1 stays in range
    send_word(MODE_LOAD_L, 2'd3, 2'd3, ELEM_NEG1);
    send_word(MODE_LOAD_R, 2'd3, 2'd3, 32'h0000_0001);   // -1 * 1 floors to -1
    send_word(MODE_LOAD_L, 2'd2, 2'd2, ONE_Q16);
    send_word(MODE_LOAD_R, 2'd2, 2'd3, ELEM_MIN);        // 1.0 * MIN passes through
    send_word(MODE_COMPUTE, 2'd3, 2'd3, ELEM_NEG1);
    send_word(MODE_UNUSED, 2'd0, 2'd0, 32'h0);
    send_word(MODE_COMPUTE, 2'd1, 2'd2, ELEM_MIN);
  endtask

  task automatic test_random_traffic(input int words);
    run_matrix_sets(words);
  endtask

  // Sender stops until every product word is back, then carries on.
  task automatic test_drain_pause();
    run_matrix_sets(12);
    wait_for_products();
    run_matrix_sets(12);
  endtask

  // No idling on either side: back-to-back loads and computes.
  task automatic test_full_throughput();
    quiet = 1'b1;
    run_matrix_sets(30);
    quiet = 1'b0;
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // compute pipeline freezes, the command queue fills and cmd_stall rises.
  task automatic test_result_holdoff();
    rx_hold_left = HOLDOFF_CYCLES;
    for (int n = 0; n < 4; n++)
      send_word(MODE_LOAD_L, 2'(n), 2'(3 - n), rand_element());
    send_word(MODE_COMPUTE, 2'd0, 2'd0, 32'h0);
    for (int n = 0; n < 4; n++)
      send_word(MODE_LOAD_R, 2'(n), 2'(n), rand_element());
    send_word(MODE_COMPUTE, 2'd0, 2'd0, 32'h0);
    for (int n = 0; n < 6; n++)
      send_word($urandom_range(1) ? MODE_LOAD_R : MODE_LOAD_L,
                2'($urandom), 2'($urandom), rand_element());
    wait_for_products();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a counted hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      res_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      res_stall <= !quiet && ($urandom_range(99) < 24);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted word against the oldest expectation.
  // Sampled at the edge, so these are the values the handshake used.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_products
    product_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_products.size() == 0) begin
        $error("unexpected product word: product %h row %0d col %0d last %b",
               product, out_row, out_col, last);
        mismatches++;
      end else begin
        want = pending_products.pop_front();
        if (product !== want.product) begin
          $error("product: expected %h, got %h", want.product, product);
          mismatches++;
        end
        if (out_row !== want.r) begin
          $error("out_row: expected %0d, got %0d", want.r, out_row);
          mismatches++;
        end
        if (out_col !== want.c) begin
          $error("out_col: expected %0d, got %0d", want.c, out_col);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, got %b", want.last, last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no word accepted on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("matrix4x4_multiply_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(30);
    test_drain_pause();
    test_full_throughput();
    test_result_holdoff();
    test_random_traffic(25);

    // let the last products out, then a short tail for anything extra
    wait_for_products();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_products.size() != 0) begin
      $error("%0d product words never arrived", pending_products.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("matrix4x4_multiply_core: match");
    end else begin
      $display("matrix4x4_multiply_core: mismatch");
    end
    $finish;
  end

endmodule
